/* rtl/core/tcgr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

  // Screen and font geometry.
  localparam int unsigned SCREEN_WIDTH = 800;
  localparam int unsigned TEXT_LINES   = 24;
  localparam int unsigned GLYPH_HEIGHT = 20;
  localparam int unsigned GLYPH_WIDTH  = 10;
  localparam int unsigned GLYPH_COUNT  = 256;
  localparam int unsigned STORE_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int unsigned LINE_PITCH   = SCREEN_WIDTH * GLYPH_HEIGHT;

  // Field and state widths.
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned BITS_W  = 10;
  localparam int unsigned ADDR_W  = 19;
  localparam int unsigned LINE_W  = 5;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned IDX_W   = $clog2(STORE_DEPTH);
  localparam int unsigned GROW_W  = $clog2(GLYPH_HEIGHT);

  // Request and result codes.
  localparam logic REQ_CHAR    = 1'b0;
  localparam logic REQ_LOAD    = 1'b1;
  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // Character codes with special meaning.
  localparam logic [CODE_W-1:0] CODE_LF     = 8'd10;
  localparam logic [CODE_W-1:0] CODE_CR     = 8'd13;
  localparam logic [CODE_W-1:0] CODE_DELETE = 8'd127;
  localparam logic [CODE_W-1:0] CODE_SPACE  = 8'd32;

  typedef struct packed {
    logic              req_type;
    logic [CODE_W-1:0] char_code;
    logic [CODE_W-1:0] load_glyph;
    logic [ROW_W-1:0]  load_row;
    logic [BITS_W-1:0] load_bits;
  } tcgr_in_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] pixel_address;
    logic [BITS_W-1:0] row_pixels;
    logic              last_of_run;
  } tcgr_out_t;

  typedef struct packed {
    logic capture;
    logic store_write;
    logic new_line;
    logic start_print;
    logic start_delete;
    logic emit_row;
    logic emit_last;
    logic emit_scroll;
  } tcgr_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_newline;
    logic is_delete;
    logic col_zero;
    logic wrap;
    logic line_top;
    logic row_last;
    logic out_free;
  } tcgr_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ROWS,
    ST_SCROLL
  } tcgr_state_e;

endpackage

`default_nettype wire

/* rtl/core/tcgr_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tcgr_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [tcgr_pkg::CODE_W-1:0] char_code;
  logic [tcgr_pkg::CODE_W-1:0] load_glyph;
  logic [tcgr_pkg::ROW_W-1:0]  load_row;
  logic [tcgr_pkg::BITS_W-1:0] load_bits;

  modport source (
    output valid, req_type, char_code, load_glyph, load_row, load_bits,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, load_glyph, load_row, load_bits,
    output ready
  );
endinterface

interface tcgr_res_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [tcgr_pkg::ADDR_W-1:0] pixel_address;
  logic [tcgr_pkg::BITS_W-1:0] row_pixels;
  logic                        last_of_run;

  modport source (
    output valid, result_kind, pixel_address, row_pixels, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, pixel_address, row_pixels, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/tcgr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcgr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tcgr_pkg::tcgr_sts_t sts_i,
  output tcgr_pkg::tcgr_cmd_t      cmd_o
);
  import tcgr_pkg::*;

  tcgr_state_e state_q, state_d;
  logic        scroll_q, scroll_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      scroll_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      scroll_q <= scroll_d;
    end
  end

  // Next state.
  always_comb begin
    state_d  = state_q;
    scroll_d = scroll_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        scroll_d = 1'b0;
        if (sts_i.is_load) begin
          state_d = ST_IDLE;
        end else if (sts_i.is_newline) begin
          state_d = sts_i.line_top ? ST_SCROLL : ST_IDLE;
        end else if (sts_i.is_delete) begin
          state_d = sts_i.col_zero ? ST_IDLE : ST_ROWS;
        end else begin
          // A character that runs off the last line scrolls after its rows.
          scroll_d = sts_i.wrap && sts_i.line_top;
          state_d  = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (sts_i.out_free && sts_i.row_last) begin
          state_d = scroll_q ? ST_SCROLL : ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        if (sts_i.is_load) begin
          cmd_o.store_write = 1'b1;
        end else if (sts_i.is_newline) begin
          cmd_o.new_line = 1'b1;
        end else if (sts_i.is_delete) begin
          cmd_o.start_delete = !sts_i.col_zero;
        end else begin
          cmd_o.start_print = 1'b1;
        end
      end
      ST_ROWS: begin
        cmd_o.emit_row  = sts_i.out_free;
        cmd_o.emit_last = sts_i.row_last && !scroll_q;
      end
      ST_SCROLL: begin
        cmd_o.emit_scroll = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/tcgr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcgr_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tcgr_pkg::tcgr_in_t   in_i,
  input  wire tcgr_pkg::tcgr_cmd_t  cmd_i,
  output tcgr_pkg::tcgr_sts_t       sts_o,
  output tcgr_pkg::tcgr_out_t       out_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i
);
  import tcgr_pkg::*;

  localparam logic [IDX_W-1:0] SPACE_IDX = IDX_W'(32'(CODE_SPACE) * GLYPH_HEIGHT);

  tcgr_in_t          in_q;
  logic [LINE_W-1:0] line_q;
  logic [COL_W-1:0]  col_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [GROW_W-1:0] row_q;
  logic [ADDR_W-1:0] addr_q;
  logic [BITS_W-1:0] rdata_q;
  tcgr_out_t         out_q;
  logic              out_valid_q;

  logic [BITS_W-1:0] store_mem [STORE_DEPTH];

  logic [COL_W-1:0]  col_back;
  logic [COL_W:0]    col_adv;
  logic [LINE_W:0]   line_inc;
  logic [LINE_W-1:0] line_next;
  logic [COL_W-1:0]  base_col;
  logic [ADDR_W-1:0] base_addr;
  logic [IDX_W-1:0]  load_idx;
  logic              load_ok;

  assign col_back  = (col_q >= COL_W'(GLYPH_WIDTH)) ? col_q - COL_W'(GLYPH_WIDTH) : '0;
  assign col_adv   = {1'b0, col_q} + (COL_W + 1)'(GLYPH_WIDTH);
  assign line_inc  = {1'b0, line_q} + (LINE_W + 1)'(1);
  assign line_next = (line_inc >= (LINE_W + 1)'(TEXT_LINES)) ?
                     LINE_W'(TEXT_LINES - 1) : line_inc[LINE_W-1:0];

  // A delete paints the cell it backs into.
  assign base_col  = cmd_i.start_delete ? col_back : col_q;
  assign base_addr = ADDR_W'(line_q) * ADDR_W'(LINE_PITCH) + ADDR_W'(base_col);

  assign load_idx = IDX_W'(in_q.load_glyph) * IDX_W'(GLYPH_HEIGHT) + IDX_W'(in_q.load_row);
  assign load_ok  = ({1'b0, in_q.load_glyph} < (CODE_W + 1)'(GLYPH_COUNT)) &&
                    (in_q.load_row < ROW_W'(GLYPH_HEIGHT));

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start_print) begin
      idx_d = IDX_W'(in_q.char_code) * IDX_W'(GLYPH_HEIGHT);
    end else if (cmd_i.start_delete) begin
      idx_d = SPACE_IDX;
    end else if (cmd_i.emit_row) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    sts_o.is_load    = (in_q.req_type == REQ_LOAD);
    sts_o.is_newline = (in_q.char_code inside {CODE_LF, CODE_CR});
    sts_o.is_delete  = (in_q.char_code == CODE_DELETE);
    sts_o.col_zero   = (col_q == '0);
    sts_o.wrap       = (col_adv >= (COL_W + 1)'(SCREEN_WIDTH));
    sts_o.line_top   = (line_inc >= (LINE_W + 1)'(TEXT_LINES));
    sts_o.row_last   = (row_q == GROW_W'(GLYPH_HEIGHT - 1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Glyph store: one write port, one registered read port that follows idx_d,
  // so rdata_q always holds the row at idx_q.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_write && load_ok) begin
      store_mem[load_idx] <= in_q.load_bits;
    end
    rdata_q <= store_mem[idx_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_i;
    end
    idx_q <= idx_d;
    if (cmd_i.start_print || cmd_i.start_delete) begin
      row_q  <= '0;
      addr_q <= base_addr;
    end else if (cmd_i.emit_row) begin
      row_q  <= row_q + GROW_W'(1);
      addr_q <= addr_q + ADDR_W'(SCREEN_WIDTH);
    end
    if (cmd_i.emit_row) begin
      out_q.result_kind   <= KIND_ROW;
      out_q.pixel_address <= addr_q;
      out_q.row_pixels    <= rdata_q;
      out_q.last_of_run   <= cmd_i.emit_last;
    end else if (cmd_i.emit_scroll) begin
      out_q.result_kind   <= KIND_SCROLL;
      out_q.pixel_address <= '0;
      out_q.row_pixels    <= '0;
      out_q.last_of_run   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.new_line) begin
        line_q <= line_next;
        col_q  <= '0;
      end else if (cmd_i.start_print) begin
        if (sts_o.wrap) begin
          line_q <= line_next;
          col_q  <= '0;
        end else begin
          col_q <= col_adv[COL_W-1:0];
        end
      end else if (cmd_i.start_delete) begin
        col_q <= col_back;
      end
      if (cmd_i.emit_row || cmd_i.emit_scroll) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/text_console_glyph_renderer.sv */
`timescale 1ns / 1ps
`default_nettype none

// A character word is decoded in the cycle after acceptance; its 20 glyph rows then leave
// the glyph store one per cycle while the output is not stalled. A character that wraps
// off the last line then sends a scroll word. Font loads, newlines and deletes at column
// zero send no row words, and a newline on the last line sends only a scroll word. Reset
// clears the text line and pixel column and empties the output register; the glyph store
// is not cleared and must be loaded before use.
module text_console_glyph_renderer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcgr_req_if.sink  req_i,
  tcgr_res_if.source res_o
);
  import tcgr_pkg::*;

  tcgr_in_t  in_word;
  tcgr_out_t out_word;
  tcgr_cmd_t cmd;
  tcgr_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  assign in_word.req_type   = req_i.req_type;
  assign in_word.char_code  = req_i.char_code;
  assign in_word.load_glyph = req_i.load_glyph;
  assign in_word.load_row   = req_i.load_row;
  assign in_word.load_bits  = req_i.load_bits;
  assign req_i.ready        = in_ready;

  tcgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcgr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_word),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_word),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready)
  );

  assign res_o.valid         = out_valid;
  assign res_o.result_kind   = out_word.result_kind;
  assign res_o.pixel_address = out_word.pixel_address;
  assign res_o.row_pixels    = out_word.row_pixels;
  assign res_o.last_of_run   = out_word.last_of_run;

endmodule

`default_nettype wire

/* test/tb_text_console_glyph_renderer.sv */
`timescale 1ns / 1ps

module tb_text_console_glyph_renderer;
  import tcgr_pkg::*;

  localparam int RANDOM_ITEMS = 340;
  localparam int MAX_IDLE     = 17;
  localparam int LONG_HOLD    = 400;
  localparam int TRAIL_CYCLES = 64;

  typedef struct packed {
    logic     silent;
    tcgr_in_t item;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  tcgr_req_if req_bus ();
  tcgr_res_if res_bus ();

  text_console_glyph_renderer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  // Console model: font rows and the cursor.
  logic [BITS_W-1:0] font_rows   [STORE_DEPTH];
  int unsigned       cur_line;
  int unsigned       cur_col;
  tcgr_out_t         due_words [$];

  // Codes whose twenty rows are all known to be loaded.
  logic [CODE_W-1:0] printable_codes [$];

  stim_row_t directed_rows [19];
  logic      directed_silent;
  bit        src_idle_on;
  bit        snk_idle_on;
  int        hold_request;
  int        items_sent;
  int        mismatches;
  int        words_checked;
  int        scrolls_seen;
  int        chars_seen;
  int        loads_seen;
  int        feeds_seen;
  int        deletes_seen;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void queue_word(logic kind, logic [ADDR_W-1:0] addr,
                                     logic [BITS_W-1:0] bits);
    tcgr_out_t w;
    w.result_kind   = kind;
    w.pixel_address = addr;
    w.row_pixels    = bits;
    w.last_of_run   = 1'b0;
    due_words.push_back(w);
  endfunction

  function automatic void line_feed();
    cur_line++;
    cur_col = 0;
    if (cur_line >= TEXT_LINES) begin
      queue_word(KIND_SCROLL, '0, '0);
      cur_line = TEXT_LINES - 1;
    end
  endfunction

  function automatic void paint_cell(logic [CODE_W-1:0] code);
    int unsigned base;
    base = cur_line * LINE_PITCH + cur_col;
    for (int r = 0; r < GLYPH_HEIGHT; r++) begin
      queue_word(KIND_ROW, ADDR_W'(base + r * SCREEN_WIDTH),
                 font_rows[code * GLYPH_HEIGHT + r]);
    end
    cur_col += GLYPH_WIDTH;
    if (cur_col >= SCREEN_WIDTH) line_feed();
  endfunction

  function automatic void advance_console(tcgr_in_t it);
    int first;
    int unsigned idx;
    first = due_words.size();
    if (it.req_type == REQ_LOAD) begin
      loads_seen++;
      if (it.load_row < GLYPH_HEIGHT && it.load_glyph < GLYPH_COUNT) begin
        idx = it.load_glyph * GLYPH_HEIGHT + it.load_row;
        font_rows[idx] = it.load_bits;
      end
    end else if (it.char_code == CODE_LF || it.char_code == CODE_CR) begin
      feeds_seen++;
      line_feed();
    end else if (it.char_code == CODE_DELETE) begin
      deletes_seen++;
      // Back up one cell, blank it, and leave the cursor on the blanked cell.
      if (cur_col > 0) begin
        cur_col = (cur_col >= GLYPH_WIDTH) ? cur_col - GLYPH_WIDTH : 0;
        paint_cell(CODE_SPACE);
        cur_col = (cur_col >= GLYPH_WIDTH) ? cur_col - GLYPH_WIDTH : 0;
      end
    end else begin
      chars_seen++;
      paint_cell(it.char_code);
    end
    if (due_words.size() > first) due_words[due_words.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic tcgr_in_t noise_item();
    tcgr_in_t it;
    it.req_type   = 1'($urandom_range(0, 1));
    it.char_code  = CODE_W'($urandom_range(0, 255));
    it.load_glyph = CODE_W'($urandom_range(0, 255));
    it.load_row   = ROW_W'($urandom_range(0, 31));
    it.load_bits  = BITS_W'($urandom_range(0, 1023));
    return it;
  endfunction

  function automatic tcgr_in_t char_item(logic [CODE_W-1:0] code);
    tcgr_in_t it;
    it           = noise_item();
    it.req_type  = REQ_CHAR;
    it.char_code = code;
    return it;
  endfunction

  function automatic tcgr_in_t load_item(logic [CODE_W-1:0] glyph, logic [ROW_W-1:0] row);
    tcgr_in_t it;
    int pick;
    it            = noise_item();
    it.req_type   = REQ_LOAD;
    it.load_glyph = glyph;
    it.load_row   = row;
    pick          = $urandom_range(0, 9);
    if (pick == 0) it.load_bits = '0;
    else if (pick == 1) it.load_bits = '1;
    return it;
  endfunction

  // Both the predictor update and the check run here, so their order at one edge is fixed.
  always @(posedge clk_i) begin : watch
    tcgr_out_t got;
    tcgr_out_t want;
    int first;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        first = due_words.size();
        advance_console({req_bus.req_type, req_bus.char_code, req_bus.load_glyph,
                         req_bus.load_row, req_bus.load_bits});
        // A silent table row must cause no word at all.
        if (directed_silent) begin
          while (due_words.size() > first) void'(due_words.pop_back());
        end
      end
      if (res_bus.valid && res_bus.ready) begin
        got = {res_bus.result_kind, res_bus.pixel_address, res_bus.row_pixels,
               res_bus.last_of_run};
        if (due_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 200)
            $display("%0t: unexpected word, expected none, got kind %0d addr %0d pixels %h last %0d",
                     $time, got.result_kind, got.pixel_address, got.row_pixels,
                     got.last_of_run);
        end else begin
          want = due_words.pop_front();
          words_checked++;
          if (want.result_kind == KIND_SCROLL) scrolls_seen++;
          if (got.result_kind !== want.result_kind) begin
            mismatches++;
            if (mismatches <= 200)
              $display("%0t: result_kind expected %0d, got %0d", $time,
                       want.result_kind, got.result_kind);
          end
          if (got.pixel_address !== want.pixel_address) begin
            mismatches++;
            if (mismatches <= 200)
              $display("%0t: pixel_address expected %0d, got %0d", $time,
                       want.pixel_address, got.pixel_address);
          end
          if (got.row_pixels !== want.row_pixels) begin
            mismatches++;
            if (mismatches <= 200)
              $display("%0t: row_pixels expected %h, got %h", $time,
                       want.row_pixels, got.row_pixels);
          end
          if (got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= 200)
              $display("%0t: last_of_run expected %0d, got %0d", $time,
                       want.last_of_run, got.last_of_run);
          end
        end
      end
    end
  end

  // Receiver: stalls at random before each word while sink idling is on, or holds long on request.
  initial begin : receiver
    int stall;
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = snk_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_bus.valid === 1'b1 && res_bus.ready));
    end
  end

  task automatic send_item(tcgr_in_t it, logic silent);
    int gap;
    gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= it.req_type;
    req_bus.char_code  <= it.char_code;
    req_bus.load_glyph <= it.load_glyph;
    req_bus.load_row   <= it.load_row;
    req_bus.load_bits  <= it.load_bits;
    directed_silent    <= silent;
    do @(posedge clk_i); while (!(req_bus.valid && req_bus.ready));
    items_sent++;
  endtask

  // Waits past the edge of the last acceptance so its words are already queued.
  task automatic wait_for_drain();
    @(negedge clk_i);
    while (due_words.size() != 0) @(posedge clk_i);
  endtask

  // Loads a whole glyph in row order, now and then with an out-of-range row mixed in.
  task automatic load_glyph_sequence(logic [CODE_W-1:0] glyph);
    for (int r = 0; r < GLYPH_HEIGHT; r++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(load_item(CODE_W'($urandom_range(0, 255)),
                            ROW_W'($urandom_range(GLYPH_HEIGHT, 31))), 1'b0);
      send_item(load_item(glyph, ROW_W'(r)), 1'b0);
    end
    if (glyph != CODE_LF && glyph != CODE_CR && glyph != CODE_DELETE)
      printable_codes.push_back(glyph);
  endtask

  task automatic text_run(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 64)
        send_item(char_item(printable_codes[$urandom_range(0, printable_codes.size() - 1)]),
                  1'b0);
      else if (pick < 79)
        send_item(char_item($urandom_range(0, 1) ? CODE_LF : CODE_CR), 1'b0);
      else if (pick < 91)
        send_item(char_item(CODE_DELETE), 1'b0);
      else
        send_item(load_item(CODE_W'($urandom_range(0, 255)),
                            ROW_W'($urandom_range(0, 31))), 1'b0);
    end
  endtask

  // Enough characters without a line break to wrap at the right edge from any column.
  task automatic fill_line();
    for (int i = 0; i <= SCREEN_WIDTH / GLYPH_WIDTH; i++) begin
      send_item(char_item(printable_codes[$urandom_range(0, printable_codes.size() - 1)]),
                1'b0);
    end
  endtask

  initial begin : timeout
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int start;
    bit pressure_done;
    bit pause_done;
    bit fill_done;
    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_CHAR;
    req_bus.char_code  = '0;
    req_bus.load_glyph = '0;
    req_bus.load_row   = '0;
    req_bus.load_bits  = '0;
    directed_silent    = 1'b0;
    src_idle_on        = 1'b1;
    snk_idle_on        = 1'b1;
    hold_request       = 0;
    items_sent         = 0;
    mismatches         = 0;
    words_checked      = 0;
    scrolls_seen       = 0;
    chars_seen         = 0;
    loads_seen         = 0;
    feeds_seen         = 0;
    deletes_seen       = 0;
    cur_line           = 0;
    cur_col            = 0;
    pressure_done      = 1'b0;
    pause_done         = 1'b0;
    fill_done          = 1'b0;

    directed_rows = '{
      {1'b1, REQ_CHAR, CODE_DELETE, 8'd0,       5'd0,  10'h000},  // delete at column zero
      {1'b1, REQ_CHAR, CODE_LF,     8'hFF,      5'd31, 10'h3FF},
      {1'b1, REQ_CHAR, CODE_CR,     8'd0,       5'd0,  10'h000},
      {1'b1, REQ_LOAD, 8'hFF,       8'd0,       5'd0,  10'h000},
      {1'b1, REQ_LOAD, 8'd0,        8'd255,     5'd19, 10'h3FF},
      {1'b1, REQ_LOAD, 8'd0,        CODE_SPACE, 5'd5,  10'h155},
      {1'b1, REQ_LOAD, 8'd0,        8'd0,       5'd20, 10'h3FF},  // row out of range
      {1'b1, REQ_LOAD, 8'hFF,       8'd255,     5'd31, 10'h2AA},  // row out of range
      {1'b0, REQ_CHAR, 8'd0,        8'hFF,      5'd31, 10'h3FF},
      {1'b0, REQ_CHAR, 8'd255,      8'd0,       5'd0,  10'h000},
      {1'b0, REQ_CHAR, CODE_SPACE,  8'd0,       5'd0,  10'h000},
      {1'b0, REQ_CHAR, 8'd128,      8'hAA,      5'd10, 10'h2AA},
      {1'b0, REQ_CHAR, CODE_DELETE, 8'd0,       5'd0,  10'h000},
      {1'b0, REQ_CHAR, CODE_DELETE, 8'h55,      5'd21, 10'h155},
      {1'b0, REQ_CHAR, CODE_DELETE, 8'd0,       5'd0,  10'h000},
      {1'b0, REQ_CHAR, CODE_DELETE, 8'd0,       5'd0,  10'h000},
      {1'b1, REQ_CHAR, CODE_DELETE, 8'd0,       5'd0,  10'h000},  // back at column zero
      {1'b0, REQ_CHAR, 8'd255,      8'd0,       5'd0,  10'h000},
      {1'b1, REQ_CHAR, CODE_CR,     8'd0,       5'd0,  10'h000}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The glyph store holds nothing after reset, so the glyphs in use are loaded first.
    load_glyph_sequence(8'd0);
    load_glyph_sequence(CODE_SPACE);
    load_glyph_sequence(8'd128);
    load_glyph_sequence(8'd255);

    foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].silent);
    wait_for_drain();

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      src_idle_on = $urandom_range(0, 4) != 0;
      snk_idle_on = $urandom_range(0, 4) != 0;
      if (!fill_done && items_sent - start >= 60) begin
        fill_done = 1'b1;
        fill_line();
      end else if (!pressure_done && items_sent - start >= 180) begin
        // Hold the output off while words keep coming, so the input has to stall.
        pressure_done = 1'b1;
        hold_request  = LONG_HOLD;
        src_idle_on   = 1'b0;
        text_run(30);
      end else if (!pause_done && items_sent - start >= 300) begin
        pause_done = 1'b1;
        wait_for_drain();
        fill_line();
      end else if ($urandom_range(0, 99) < 18) begin
        load_glyph_sequence(CODE_W'($urandom_range(0, 255)));
      end else begin
        text_run($urandom_range(1, 12));
      end
    end

    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    wait_for_drain();
    repeat (TRAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d characters, %0d newlines, %0d deletes and %0d font row loads.",
             chars_seen, feeds_seen, deletes_seen, loads_seen);
    $display("Checked %0d result words, %0d of them scrolls.", words_checked, scrolls_seen);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tcgr_pkg.sv
rtl/core/tcgr_if.sv
rtl/core/tcgr_ctrl.sv
rtl/core/tcgr_datapath.sv
rtl/core/text_console_glyph_renderer.sv
test/tb_text_console_glyph_renderer.sv
